// ----- hw/rtl/feec_pkg.sv -----
// Shared types, codes and default sizes for the flash EEPROM emulation controller.
`default_nettype none

package feec_pkg;

  localparam int FLASH_W = 18;
  localparam int ADDR_W  = 16;
  localparam int DATA_W  = 8;
  localparam int KIND_W  = 3;

  localparam int EEPROM_BYTES_DEF = 4096;
  localparam int PAGE_BYTES_DEF   = 64;
  localparam int ROW_BYTES_DEF    = 256;

  localparam logic [FLASH_W-1:0] FLASH_BASE_RESET = 18'h3F000;
  localparam logic [DATA_W-1:0]  ERASED_BYTE      = 8'hFF;

  typedef enum logic [KIND_W-1:0] {
    KIND_READ      = 3'd0,
    KIND_IGNORED   = 3'd1,
    KIND_UNCHANGED = 3'd2,
    KIND_ERASE     = 3'd3,
    KIND_PROGRAM   = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_PAGES
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_step;
    logic capture;
    logic emit_first;
    logic emit_page;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;
    logic slot_free;
    logic erase_more;
    logic page_last;
  } sts_t;

endpackage

`default_nettype wire

// ----- hw/rtl/feec_ctrl.sv -----
// Controller state machine: clearing pass, item capture, lookup and page sequencing.
`default_nettype none

module feec_ctrl
  import feec_pkg::*;
(
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  in_valid_i,
  output logic in_stall_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (sts_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (sts_i.slot_free) begin
          cmd_o.emit_first = 1'b1;
          state_d          = sts_i.erase_more ? ST_PAGES : ST_IDLE;
        end
      end
      ST_PAGES: begin
        if (sts_i.slot_free) begin
          cmd_o.emit_page = 1'b1;
          if (sts_i.page_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- hw/rtl/feec_datapath.sv -----
// Datapath: byte store, item registers, flash address forming and result register.
`default_nettype none

module feec_datapath
  import feec_pkg::*;
#(
  parameter int EEPROM_BYTES = EEPROM_BYTES_DEF,
  parameter int PAGE_BYTES   = PAGE_BYTES_DEF,
  parameter int ROW_BYTES    = ROW_BYTES_DEF
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  cmd_t               cmd_i,
  output sts_t               sts_o,
  input  wire                cfg_we_i,
  input  wire  [FLASH_W-1:0] cfg_wdata_i,
  input  wire                op_i,
  input  wire  [ADDR_W-1:0]  address_i,
  input  wire  [DATA_W-1:0]  write_data_i,
  input  wire                out_stall_i,
  output logic               out_valid_o,
  output logic [KIND_W-1:0]  kind_o,
  output logic [FLASH_W-1:0] flash_address_o,
  output logic [DATA_W-1:0]  read_data_o,
  output logic               last_o
);

  localparam int IW          = (EEPROM_BYTES > 1) ? $clog2(EEPROM_BYTES) : 1;
  localparam int PagesPerRow = ROW_BYTES / PAGE_BYTES;
  localparam int LastPage    = (PagesPerRow > 0) ? PagesPerRow - 1 : 0;
  localparam int CW          = (PagesPerRow > 1) ? $clog2(PagesPerRow) : 1;

  localparam logic [IW-1:0]      LastIdx   = IW'(EEPROM_BYTES - 1);
  localparam logic [CW-1:0]      LastCnt   = CW'(LastPage);
  localparam logic [FLASH_W-1:0] PageMask  = ~FLASH_W'(PAGE_BYTES - 1);
  localparam logic [FLASH_W-1:0] RowMask   = ~FLASH_W'(ROW_BYTES - 1);
  localparam logic [FLASH_W-1:0] PageStep  = FLASH_W'(PAGE_BYTES);
  localparam logic [ADDR_W:0]    DepthCmp  = (ADDR_W + 1)'(EEPROM_BYTES);
  localparam logic               EraseLast = (PagesPerRow == 0);

  logic [DATA_W-1:0] mem_q [EEPROM_BYTES];

  logic [FLASH_W-1:0] flash_base_q;
  logic [IW-1:0]      clr_q;
  logic               op_q;
  logic [ADDR_W-1:0]  addr_q;
  logic [DATA_W-1:0]  data_q;
  logic [DATA_W-1:0]  rd_q;
  logic [FLASH_W-1:0] page_q;
  logic [CW-1:0]      cnt_q;

  logic               out_valid_q;
  kind_e              kind_q;
  logic [FLASH_W-1:0] faddr_q;
  logic [DATA_W-1:0]  rdata_q;
  logic               last_q;

  logic               in_range;
  logic               equal;
  logic               clear_only;
  logic               writes;
  logic               sets_bits;
  logic [FLASH_W-1:0] faddr;
  logic [FLASH_W-1:0] row_base;
  logic               mem_we;
  logic [IW-1:0]      mem_waddr;
  logic [DATA_W-1:0]  mem_wdata;
  logic               slot_free;
  logic               page_last;

  assign in_range   = {1'b0, addr_q} < DepthCmp;
  assign equal      = (rd_q == data_q);
  assign clear_only = ((rd_q & data_q) == data_q);
  assign writes     = op_q && in_range && !equal;
  assign sets_bits  = writes && !clear_only;
  assign faddr      = flash_base_q + FLASH_W'(addr_q);
  assign row_base   = faddr & RowMask;
  assign slot_free  = !out_valid_q || !out_stall_i;
  assign page_last  = (cnt_q == LastCnt);

  assign sts_o.clear_last = (clr_q == LastIdx);
  assign sts_o.slot_free  = slot_free;
  assign sts_o.erase_more = sets_bits && !EraseLast;
  assign sts_o.page_last  = page_last;

  // One write port shared by the clearing pass and the store of a changed byte.
  assign mem_we    = cmd_i.clear_step || (cmd_i.emit_first && writes);
  assign mem_waddr = cmd_i.clear_step ? clr_q : addr_q[IW-1:0];
  assign mem_wdata = cmd_i.clear_step ? ERASED_BYTE : data_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      rd_q <= mem_q[address_i[IW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flash_base_q <= FLASH_BASE_RESET;
      clr_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        flash_base_q <= cfg_wdata_i;
      end
      if (cmd_i.clear_step) begin
        clr_q <= clr_q + 1'b1;
      end
      if (cmd_i.emit_first || cmd_i.emit_page) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= op_i;
      addr_q <= address_i;
      data_q <= write_data_i;
    end
    if (cmd_i.emit_first) begin
      page_q <= row_base;
      cnt_q  <= '0;
      if (!op_q) begin
        kind_q  <= KIND_READ;
        faddr_q <= '0;
        rdata_q <= in_range ? rd_q : ERASED_BYTE;
        last_q  <= 1'b1;
      end else if (!in_range) begin
        kind_q  <= KIND_IGNORED;
        faddr_q <= '0;
        rdata_q <= '0;
        last_q  <= 1'b1;
      end else if (equal) begin
        kind_q  <= KIND_UNCHANGED;
        faddr_q <= '0;
        rdata_q <= '0;
        last_q  <= 1'b1;
      end else if (clear_only) begin
        kind_q  <= KIND_PROGRAM;
        faddr_q <= faddr & PageMask;
        rdata_q <= '0;
        last_q  <= 1'b1;
      end else begin
        kind_q  <= KIND_ERASE;
        faddr_q <= row_base;
        rdata_q <= '0;
        last_q  <= EraseLast;
      end
    end else if (cmd_i.emit_page) begin
      kind_q  <= KIND_PROGRAM;
      faddr_q <= page_q;
      rdata_q <= '0;
      last_q  <= page_last;
      page_q  <= page_q + PageStep;
      cnt_q   <= cnt_q + 1'b1;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign kind_o          = kind_q;
  assign flash_address_o = faddr_q;
  assign read_data_o     = rdata_q;
  assign last_o          = last_q;

  a_read_no_addr : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (kind_q == KIND_READ) |-> (faddr_q == '0))
    else $error("read reply carries a flash address");

  a_data_only_on_read : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (kind_q != KIND_READ) |-> (rdata_q == '0))
    else $error("command beat carries read data");

  a_erase_not_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (kind_q == KIND_ERASE) |-> (last_q == EraseLast))
    else $error("row erase beat has wrong last flag");

  a_clear_exclusive : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear_step |-> !(cmd_i.capture || cmd_i.emit_first || cmd_i.emit_page))
    else $error("item activity during clearing pass");

endmodule

`default_nettype wire

// ----- hw/rtl/flash_eeprom_emulation_controller_core.sv -----
// Flow: a beat is captured in ST_IDLE, looked up in ST_LOOKUP once the output register is free, and
// its first result is then registered for output. The core takes no new item until every result of
// the last one has entered the single-result output register; an erasing write also runs the page sequencer.
// Reset: the store is swept to 0xFF, each of its EEPROM_BYTES entries in turn, through its one
// write port; in_stall_o stays high during the sweep, while configuration writes are still taken.
// flash_base resets to 0x3F000.
`default_nettype none

module flash_eeprom_emulation_controller_core
  import feec_pkg::*;
#(
  parameter int EEPROM_BYTES = EEPROM_BYTES_DEF,
  parameter int PAGE_BYTES   = PAGE_BYTES_DEF,
  parameter int ROW_BYTES    = ROW_BYTES_DEF
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                cfg_we_i,
  input  wire  [FLASH_W-1:0] cfg_wdata_i,
  input  wire                in_valid_i,
  output logic               in_stall_o,
  input  wire                op_i,
  input  wire  [ADDR_W-1:0]  address_i,
  input  wire  [DATA_W-1:0]  write_data_i,
  output logic               out_valid_o,
  input  wire                out_stall_i,
  output logic [KIND_W-1:0]  kind_o,
  output logic [FLASH_W-1:0] flash_address_o,
  output logic [DATA_W-1:0]  read_data_o,
  output logic               last_o
);

  cmd_t cmd;
  sts_t sts;

  feec_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  feec_datapath #(
    .EEPROM_BYTES (EEPROM_BYTES),
    .PAGE_BYTES   (PAGE_BYTES),
    .ROW_BYTES    (ROW_BYTES)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .op_i            (op_i),
    .address_i       (address_i),
    .write_data_i    (write_data_i),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .kind_o          (kind_o),
    .flash_address_o (flash_address_o),
    .read_data_o     (read_data_o),
    .last_o          (last_o)
  );

endmodule

`default_nettype wire

// ----- tb/flash_eeprom_emulation_controller_core_tb.sv -----
// Testbench for the flash EEPROM emulation core: random and directed byte traffic.
`timescale 1ns / 100ps

module flash_eeprom_emulation_controller_core_tb
  import feec_pkg::*;
;

  localparam int EEPROM_BYTES  = EEPROM_BYTES_DEF;
  localparam int PAGE_BYTES    = PAGE_BYTES_DEF;
  localparam int ROW_BYTES     = ROW_BYTES_DEF;
  localparam int PAGES_PER_ROW = ROW_BYTES / PAGE_BYTES;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam int QUIET_LIMIT   = 20000;
  localparam int LONG_HOLD     = 120;
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_PRINTED   = 60;

  typedef struct {
    kind_e              kind;
    logic [FLASH_W-1:0] cmd_addr;
    logic [DATA_W-1:0]  rdata;
    logic               last;
  } flash_result_t;

  // Mirror of the emulated store plus the queue of commands the core still owes us.
  class flash_cmd_scoreboard;
    logic [DATA_W-1:0]  mirror_bytes [EEPROM_BYTES];
    logic [FLASH_W-1:0] flash_base;
    flash_result_t      owed_q [$];
    int                 errors;
    int                 beats_in;
    int                 kind_seen [5];

    function new();
      foreach (mirror_bytes[i]) mirror_bytes[i] = ERASED_BYTE;
      flash_base = FLASH_BASE_RESET;
      errors     = 0;
      beats_in   = 0;
      foreach (kind_seen[i]) kind_seen[i] = 0;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    function logic [DATA_W-1:0] stored_byte(logic [ADDR_W-1:0] addr);
      return (addr < EEPROM_BYTES) ? mirror_bytes[addr] : ERASED_BYTE;
    endfunction

    function void owe(kind_e kind, logic [FLASH_W-1:0] fa, logic [DATA_W-1:0] rd, logic last);
      flash_result_t r;
      r.kind     = kind;
      r.cmd_addr = fa;
      r.rdata    = rd;
      r.last     = last;
      owed_q.push_back(r);
    endfunction

    // Works out the flash commands one accepted access causes.
    function void note_access(logic op, logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
      logic [FLASH_W-1:0] byte_fa;
      logic [FLASH_W-1:0] page_fa;
      logic [FLASH_W-1:0] row_fa;
      logic [FLASH_W-1:0] pg;
      logic [DATA_W-1:0]  old;
      logic               in_range;
      beats_in++;
      in_range = addr < EEPROM_BYTES;
      if (op == OP_READ) begin
        owe(KIND_READ, '0, stored_byte(addr), 1'b1);
      end else if (!in_range) begin
        owe(KIND_IGNORED, '0, '0, 1'b1);
      end else begin
        old     = mirror_bytes[addr];
        byte_fa = flash_base + FLASH_W'(addr);
        page_fa = byte_fa & ~FLASH_W'(PAGE_BYTES - 1);
        row_fa  = byte_fa & ~FLASH_W'(ROW_BYTES - 1);
        if (old == data) begin
          owe(KIND_UNCHANGED, '0, '0, 1'b1);
        end else begin
          mirror_bytes[addr] = data;
          if ((old & data) == data) begin
            owe(KIND_PROGRAM, page_fa, '0, 1'b1);
          end else begin
            owe(KIND_ERASE, row_fa, '0, 1'b0);
            for (int i = 0; i < PAGES_PER_ROW; i++) begin
              pg = row_fa + FLASH_W'(i * PAGE_BYTES);
              owe(KIND_PROGRAM, pg, '0, (i == PAGES_PER_ROW - 1));
            end
          end
        end
      end
    endfunction

    task report_mismatch(string what);
      errors++;
      if (errors <= MAX_PRINTED) $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    task check_result(logic [KIND_W-1:0] kind, logic [FLASH_W-1:0] fa,
                      logic [DATA_W-1:0] rd, logic last);
      flash_result_t e;
      if (owed_q.size() == 0) begin
        report_mismatch($sformatf("unexpected beat kind=%0d addr=%h data=%h last=%b",
                                  kind, fa, rd, last));
      end else begin
        e = owed_q.pop_front();
        if (e.kind <= KIND_PROGRAM) kind_seen[e.kind]++;
        if (kind !== e.kind)
          report_mismatch($sformatf("kind %0d, expected %0d", kind, e.kind));
        if (fa !== e.cmd_addr)
          report_mismatch($sformatf("flash_address %h, expected %h", fa, e.cmd_addr));
        if (rd !== e.rdata)
          report_mismatch($sformatf("read_data %h, expected %h", rd, e.rdata));
        if (last !== e.last)
          report_mismatch($sformatf("last %b, expected %b", last, e.last));
      end
    endtask
  endclass

  logic               clk_i        = 1'b0;
  logic               rst_ni       = 1'b0;
  logic               cfg_we_i     = 1'b0;
  logic [FLASH_W-1:0] cfg_wdata_i  = '0;
  logic               in_valid_i   = 1'b0;
  logic               in_stall_o;
  logic               op_i         = 1'b0;
  logic [ADDR_W-1:0]  address_i    = '0;
  logic [DATA_W-1:0]  write_data_i = '0;
  logic               out_valid_o;
  logic               out_stall_i  = 1'b0;
  logic [KIND_W-1:0]  kind_o;
  logic [FLASH_W-1:0] flash_address_o;
  logic [DATA_W-1:0]  read_data_o;
  logic               last_o;

  flash_cmd_scoreboard sb;
  int tx_idle_pct;
  int rx_stall_pct;
  int holds_requested;
  int holds_served;
  int hold_left;
  int quiet_cycles;
  int cfg_writes;

  flash_eeprom_emulation_controller_core #(
    .EEPROM_BYTES(EEPROM_BYTES),
    .PAGE_BYTES  (PAGE_BYTES),
    .ROW_BYTES   (ROW_BYTES)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .op_i           (op_i),
    .address_i      (address_i),
    .write_data_i   (write_data_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind_o),
    .flash_address_o(flash_address_o),
    .read_data_o    (read_data_o),
    .last_o         (last_o)
  );

  always #5 clk_i = ~clk_i;

  // Output side: random stall, or a long hold-off when one has been requested.
  always @(posedge clk_i) begin
    if (holds_served != holds_requested) begin
      hold_left = LONG_HOLD;
      holds_served++;
    end
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result(kind_o, flash_address_o, read_data_o, last_o);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no beat moved for %0d cycles, %0d results owed",
               QUIET_LIMIT, sb.pending());
      $display("FAIL flash_eeprom_emulation_controller_core");
      $finish;
    end
  end

  // Presents one access and returns at the edge where it is taken; valid stays high.
  task send_beat(logic op, logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
    in_valid_i   <= 1'b1;
    op_i         <= op;
    address_i    <= addr;
    write_data_i <= data;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_access(op, addr, data);
  endtask

  task idle_cycles(int n);
    in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task wait_drained();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task set_flash_base(logic [FLASH_W-1:0] base);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= base;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.flash_base = base;
    cfg_writes++;
  endtask

  function logic [ADDR_W-1:0] pick_address();
    int r;
    r = $urandom_range(99);
    if (r < 8) return ADDR_W'($urandom_range(65535));
    if (r < 14) return ADDR_W'($urandom_range(EEPROM_BYTES + 5, EEPROM_BYTES - 6));
    if (r < 35) return ADDR_W'($urandom_range(EEPROM_BYTES - 1));
    // A few hot bytes at both ends of the store so reads and rewrites hit written data.
    return ADDR_W'(($urandom_range(1) ? 0 : EEPROM_BYTES - 32) + $urandom_range(31));
  endfunction

  function logic [DATA_W-1:0] pick_write_data(logic [ADDR_W-1:0] addr);
    logic [DATA_W-1:0] old;
    int r;
    old = sb.stored_byte(addr);
    r   = $urandom_range(99);
    if (r < 20) return old;
    if (r < 55) return old & DATA_W'($urandom_range(255));
    if (r < 65) return $urandom_range(1) ? ERASED_BYTE : '0;
    return DATA_W'($urandom_range(255));
  endfunction

  task run_random(int n_items);
    logic [ADDR_W-1:0] addr;
    logic              op;
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(99) < tx_idle_pct) idle_cycles($urandom_range(1, 5));
      addr = pick_address();
      op   = ($urandom_range(99) < 45) ? OP_READ : OP_WRITE;
      send_beat(op, addr, (op == OP_WRITE) ? pick_write_data(addr)
                                            : DATA_W'($urandom_range(255)));
    end
  endtask

  initial begin
    sb              = new();
    tx_idle_pct     = 0;
    rx_stall_pct    = 0;
    holds_requested = 0;
    holds_served    = 0;
    hold_left       = 0;
    quiet_cycles    = 0;
    cfg_writes      = 0;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at the reset flash base: range edges, every command kind.
    send_beat(OP_READ,  16'd0,    8'h00);
    send_beat(OP_READ,  16'd4095, 8'hFF);
    send_beat(OP_READ,  16'd4096, 8'h00);
    send_beat(OP_READ,  16'hFFFF, 8'h00);
    send_beat(OP_WRITE, 16'd4096, 8'h12);
    send_beat(OP_WRITE, 16'hFFFF, 8'hAB);
    send_beat(OP_WRITE, 16'd0,    8'hFF);
    send_beat(OP_WRITE, 16'd0,    8'hF0);
    send_beat(OP_WRITE, 16'd0,    8'hF0);
    send_beat(OP_WRITE, 16'd0,    8'h0F);
    send_beat(OP_READ,  16'd0,    8'h00);
    send_beat(OP_WRITE, 16'd4095, 8'h00);
    send_beat(OP_WRITE, 16'd4095, 8'hFF);
    send_beat(OP_READ,  16'd4095, 8'h00);
    send_beat(OP_WRITE, 16'd2730, 8'h55);
    send_beat(OP_READ,  16'd2730, 8'h00);

    // Top of flash: the byte address wraps past the end of the 18-bit space.
    set_flash_base(18'h3FFFF);
    send_beat(OP_WRITE, 16'd1,    8'h80);
    send_beat(OP_WRITE, 16'd0,    8'h00);
    send_beat(OP_WRITE, 16'd0,    8'hFF);
    send_beat(OP_WRITE, 16'd1365, 8'hAA);

    set_flash_base(18'h00000);
    send_beat(OP_WRITE, 16'd4095, 8'h01);
    send_beat(OP_WRITE, 16'd4095, 8'h02);
    send_beat(OP_READ,  16'd4095, 8'h00);
    send_beat(OP_READ,  16'd1,    8'h00);

    // Unaligned random base, sparse sender, busy receiver; drain once halfway.
    set_flash_base(FLASH_W'($urandom_range(18'h3FFFF)));
    tx_idle_pct  = 23;
    rx_stall_pct = 70;
    run_random(65);
    wait_drained();
    run_random(65);

    set_flash_base(FLASH_W'($urandom_range(18'h3FFFF)));
    tx_idle_pct  = 70;
    rx_stall_pct = 23;
    run_random(130);

    // Full rate, opening with a long receiver hold-off so the core backs up.
    set_flash_base(FLASH_BASE_RESET);
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    holds_requested++;
    run_random(130);

    wait_drained();
    repeat (20) @(posedge clk_i);

    $display("Covered %0d accesses over %0d flash base settings, including wrap and idle gaps.",
             sb.beats_in, cfg_writes + 1);
    $display("Results seen: %0d reads, %0d ignored, %0d unchanged, %0d erases, %0d programs.",
             sb.kind_seen[KIND_READ], sb.kind_seen[KIND_IGNORED], sb.kind_seen[KIND_UNCHANGED],
             sb.kind_seen[KIND_ERASE], sb.kind_seen[KIND_PROGRAM]);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS flash_eeprom_emulation_controller_core");
    end else begin
      $display("FAIL flash_eeprom_emulation_controller_core");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/feec_pkg.sv
hw/rtl/feec_ctrl.sv
hw/rtl/feec_datapath.sv
hw/rtl/flash_eeprom_emulation_controller_core.sv
tb/flash_eeprom_emulation_controller_core_tb.sv
